### src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine: list depth, item
// structs, command and status codes, cell operations and control state.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int ECNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                       command;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  item_value;
    logic                       last;
    logic [ECNT_W-1:0]          entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_APPEND,
    OP_MATCH,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e                   op;
    logic [CNT_W-1:0]           count;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELETE,
    ST_DUMP
  } state_e;

  // Entry count as reported on the result item
  function automatic logic [ECNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] cnt);
    return ECNT_W'(cnt);
  endfunction

endpackage

### src/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_item_i under in_valid_i / in_stall_o; results leave
//   on out_item_o under out_valid_o / out_stall_i from one output register.
//   A command is taken only while the engine is idle and the output register
//   is empty or being emptied in that cycle.
//   Insert and append: one result, loaded at the edge that accepts the
//   command and offered from the next cycle; the next command can be taken
//   in the following cycle if the receiver does not stall that result.
//   Delete: the accepting cycle registers a key compare in every cell; then,
//   once the output register is free, the tail shifts one place forward
//   and the result is loaded.
//   Dump: the row rotates by one cell per delivered result, so a dump of N
//   entries leaves the list in its original order; the last result carries
//   last = 1.
//   Delete or dump on an empty list, and insert or append on a full list,
//   give a single status result at once. Reset empties the list (entry
//   count zero) and drops any pending result. While the receiver stalls,
//   the result register holds and the engine waits, taking no new command.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          dump_idx_q, dump_idx_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic                      out_free;
  logic                      in_acc;
  logic                      emit;
  out_item_t                 res;
  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] head;
  logic                      found;
  logic                      is_full;
  logic                      is_empty;
  logic                      dump_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == CNT_W'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign dump_last  = (CNT_W'(dump_idx_q) + CNT_W'(1) == count_q);

  ole_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .head_o  (head),
    .found_o (found)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !is_empty) begin
          if (in_item_i.command == CMD_DELETE) state_d = ST_DELETE;
          if (in_item_i.command == CMD_DUMP)   state_d = ST_DUMP;
        end
      end
      ST_DELETE: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_free && dump_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell operation, bookkeeping and result
  always_comb begin
    ctrl.op          = OP_HOLD;
    ctrl.count       = count_q;
    ctrl.value       = in_item_i.value;
    count_d          = count_q;
    dump_idx_d       = dump_idx_q;
    key_d            = key_q;
    emit             = 1'b0;
    res.status       = STATUS_OK;
    res.item_value   = in_item_i.value;
    res.last         = 1'b1;
    res.entry_count  = to_entry_count(count_q);
    case (state_q)
      ST_IDLE: begin
        dump_idx_d = '0;
        if (in_acc) begin
          case (in_item_i.command)
            CMD_INSERT, CMD_APPEND: begin
              emit = 1'b1;
              if (is_full) begin
                res.status = STATUS_FULL;
              end else begin
                ctrl.op         = (in_item_i.command == CMD_INSERT) ? OP_PUSH_FRONT
                                                                    : OP_APPEND;
                count_d         = count_q + CNT_W'(1);
                res.entry_count = to_entry_count(count_d);
              end
            end
            CMD_DELETE: begin
              key_d = in_item_i.value;
              if (is_empty) begin
                emit       = 1'b1;
                res.status = STATUS_EMPTY;
              end else begin
                ctrl.op = OP_MATCH;
              end
            end
            CMD_DUMP: begin
              if (is_empty) begin
                emit           = 1'b1;
                res.status     = STATUS_EMPTY;
                res.item_value = '0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_DELETE: begin
        res.item_value = key_q;
        if (out_free) begin
          emit = 1'b1;
          if (found) begin
            ctrl.op         = OP_DELETE;
            count_d         = count_q - CNT_W'(1);
            res.entry_count = to_entry_count(count_d);
          end else begin
            res.status = STATUS_NOTFOUND;
          end
        end
      end
      ST_DUMP: begin
        res.item_value = head;
        res.last       = dump_last;
        if (out_free) begin
          emit       = 1'b1;
          ctrl.op    = OP_ROTATE;
          dump_idx_d = dump_idx_q + IDX_W'(1);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
      if (out_free) out_valid_q <= emit;
    end
  end

  // Result and key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_free && emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The entry count never passes the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  // A successful insert or append grows the list by exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_full && (in_item_i.command == CMD_INSERT ||
                            in_item_i.command == CMD_APPEND))
    |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // The final dump item returns the engine to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && out_free && dump_last) |=> (state_q == ST_IDLE))
    else $error("dump did not end after its last item");

  // A full status is only reported while the list is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == STATUS_FULL) |-> is_full)
    else $error("full status on a list with room");

endmodule

### src/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry, compares it against a key and shifts
// toward either neighbor as the broadcast operation asks.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic signed [VALUE_W-1:0]  left_i,
  input  logic signed [VALUE_W-1:0]  right_i,
  input  logic signed [VALUE_W-1:0]  head_i,
  input  logic                       found_i,
  output logic                       found_o,
  output logic signed [VALUE_W-1:0]  data_o
);

  logic signed [VALUE_W-1:0] data_q, data_d;
  logic                      match_q, match_d;
  logic [CNT_W-1:0]          idx_ext;

  assign idx_ext = CNT_W'(idx_i);

  // Shift from here onward once the first match has been seen
  assign found_o = found_i | match_q;

  // Select the next entry value
  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    case (ctrl_i.op)
      OP_PUSH_FRONT: data_d = (idx_i == '0) ? ctrl_i.value : left_i;
      OP_APPEND: begin
        if (idx_ext == ctrl_i.count) data_d = ctrl_i.value;
      end
      OP_MATCH:  match_d = (data_q == ctrl_i.value) && (idx_ext < ctrl_i.count);
      OP_DELETE: begin
        if (found_o) data_d = right_i;
      end
      OP_ROTATE: data_d = (idx_ext + CNT_W'(1) == ctrl_i.count) ? head_i : right_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o = data_q;

endmodule

### src/ole_chain.sv
// ----------------------------------------------------------------------------
// ole_chain
// Row of list cells, front at index 0, with neighbor links and the
// first-match chain that runs from the front to the back.
// ----------------------------------------------------------------------------
module ole_chain import ole_pkg::*; (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  output logic signed [VALUE_W-1:0]  head_o,
  output logic                       found_o
);

  logic signed [VALUE_W-1:0] data   [DEPTH];
  logic                      found  [DEPTH+1];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val, right_val;

    // Tie off the neighbors past either end
    if (i == 0) begin : g_front
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = data[i+1];
    end

    ole_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (IDX_W'(i)),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (data[0]),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .data_o  (data[i])
    );
  end

  assign head_o  = data[0];
  assign found_o = found[DEPTH];

endmodule

### tb/tb_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Checks the ordered list engine against a shadow copy of the list. Commands
// start with a short directed table: empty list, value extremes, not-found
// key, full list and a full dump. Random commands follow, biased to fill and
// drain the list in turns. Each result is compared field by field with the
// oldest predicted result. Both sides idle at random, and once the receiver
// holds off long enough for the engine to stall its input.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
  import ole_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Shadow copy of the engine's list
  logic signed [VALUE_W-1:0] shadow_list [DEPTH];
  int                        shadow_count = 0;

  out_item_t pending_list_results [$];
  stim_row_t directed_rows [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int rx_idle_pct   = 75;
  bit pressure_go   = 1'b0;
  bit pressure_done = 1'b0;
  int pressure_left = 0;

  ordered_list_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Apply one command to the shadow list and queue the results it causes
  function automatic void apply_list_command(input in_item_t cmd);
    out_item_t res;
    int        i;
    int        hit;
    res.status      = STATUS_OK;
    res.item_value  = cmd.value;
    res.last        = 1'b1;
    case (cmd.command)
      CMD_INSERT, CMD_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          if (cmd.command == CMD_INSERT) begin
            for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[0] = cmd.value;
          end else begin
            shadow_list[shadow_count] = cmd.value;
          end
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          hit = -1;
          for (i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_list[i] == cmd.value) hit = i;
          if (hit < 0) begin
            res.status = STATUS_NOTFOUND;
          end else begin
            for (i = hit; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
          end
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status     = STATUS_EMPTY;
          res.item_value = '0;
        end else begin
          // One result per entry, front to back
          for (i = 0; i < shadow_count; i++) begin
            res.item_value  = shadow_list[i];
            res.last        = (i == shadow_count - 1);
            res.entry_count = ECNT_W'(shadow_count);
            pending_list_results.push_back(res);
          end
          return;
        end
      end
    endcase
    res.entry_count = ECNT_W'(shadow_count);
    pending_list_results.push_back(res);
  endfunction

  // Draw a value: half the time from a small pool so that duplicates and hits occur
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return int'($urandom_range(0, 8)) - 4;
    if (r < 75) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // Random command: alternate growing and shrinking stretches
  function automatic in_item_t random_command(input int idx);
    in_item_t it;
    int       r;
    bit       grow;
    grow     = ((idx / 40) % 2) == 0;
    r        = $urandom_range(0, 99);
    it.value = pick_value();
    if (grow) begin
      if (r < 45)      it.command = CMD_INSERT;
      else if (r < 80) it.command = CMD_APPEND;
      else if (r < 90) it.command = CMD_DELETE;
      else             it.command = CMD_DUMP;
    end else begin
      if (r < 10)      it.command = CMD_INSERT;
      else if (r < 20) it.command = CMD_APPEND;
      else if (r < 88) it.command = CMD_DELETE;
      else             it.command = CMD_DUMP;
    end
    // Delete keys mostly hit an entry that is held
    if (it.command == CMD_DELETE && shadow_count > 0 && $urandom_range(0, 3) != 0)
      it.value = shadow_list[$urandom_range(0, shadow_count - 1)];
    return it;
  endfunction

  task automatic add_command(input cmd_e c, input logic signed [VALUE_W-1:0] v,
                             input bit typed, input status_e st,
                             input logic signed [VALUE_W-1:0] iv, input int cnt);
    stim_row_t row;
    row.item.command      = c;
    row.item.value        = v;
    row.typed             = typed;
    row.result.status     = st;
    row.result.item_value = iv;
    row.result.last       = 1'b1;
    row.result.entry_count = ECNT_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      pressure_left <= HOLD_CYCLES;
      out_stall_i   <= 1'b1;
    end else if (pressure_left != 0) begin
      pressure_left <= pressure_left - 1;
      out_stall_i   <= 1'b1;
    end else begin
      out_stall_i   <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Check each result taken at the coming edge against the oldest prediction
  always @(negedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_list_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b count=%0d",
                                  out_item_o.status, out_item_o.item_value,
                                  out_item_o.last, out_item_o.entry_count));
      end else begin
        exp_res = pending_list_results.pop_front();
        if (out_item_o.status !== exp_res.status ||
            out_item_o.item_value !== exp_res.item_value ||
            out_item_o.last !== exp_res.last ||
            out_item_o.entry_count !== exp_res.entry_count)
          report_mismatch($sformatf(
            "got status=%0d value=%0d last=%0b count=%0d, want %0d/%0d/%0b/%0d",
            out_item_o.status, out_item_o.item_value, out_item_o.last,
            out_item_o.entry_count, exp_res.status, exp_res.item_value,
            exp_res.last, exp_res.entry_count));
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sender: directed table, then random commands, all sent in three idling phases
  initial begin
    in_item_t  it;
    stim_row_t row;
    bit        taken;
    int        n;
    int        k;
    int        total;
    int        phase;
    int        tx_idle_pct;

    add_command(CMD_DUMP,   123,     1, STATUS_EMPTY,    0,       0);
    add_command(CMD_DELETE, 5,       1, STATUS_EMPTY,    5,       0);
    add_command(CMD_INSERT, VAL_MAX, 1, STATUS_OK,       VAL_MAX, 1);
    add_command(CMD_APPEND, VAL_MIN, 1, STATUS_OK,       VAL_MIN, 2);
    add_command(CMD_DELETE, 0,       1, STATUS_NOTFOUND, 0,       2);
    add_command(CMD_APPEND, VAL_MAX, 1, STATUS_OK,       VAL_MAX, 3);
    // Duplicate key: only the front copy goes
    add_command(CMD_DELETE, VAL_MAX, 0, STATUS_OK,       0,       0);
    add_command(CMD_DUMP,   -1,      0, STATUS_OK,       0,       0);
    // Fill up from both ends
    for (k = 0; k < DEPTH - 2; k++)
      add_command((k % 2) ? CMD_APPEND : CMD_INSERT, k * 7 - 40, 0, STATUS_OK, 0, 0);
    add_command(CMD_INSERT, -1,      1, STATUS_FULL,     -1,      DEPTH);
    add_command(CMD_APPEND, 0,       1, STATUS_FULL,     0,       DEPTH);
    add_command(CMD_DUMP,   0,       0, STATUS_OK,       0,       0);

    total       = directed_rows.size() + RANDOM_ITEMS;
    tx_idle_pct = 14;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < total; n++) begin
      // Pick the idling phase
      phase = (n * 3) / total;
      if (phase == 0) begin
        tx_idle_pct = 14;
        rx_idle_pct <= 75;
      end else if (phase == 1) begin
        tx_idle_pct = 75;
        rx_idle_pct <= 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        if (!pressure_go) pressure_go <= 1'b1;
      end

      if (n < directed_rows.size()) begin
        row = directed_rows[n];
        it  = row.item;
      end else begin
        row.typed = 1'b0;
        it        = random_command(n - directed_rows.size());
      end

      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i  <= it;

      // Hold the item until taken
      do begin
        @(negedge clk_i);
        taken = !in_stall_o;
        if (taken) begin
          apply_list_command(it);
          if (row.typed) begin
            pending_list_results.delete(pending_list_results.size() - 1);
            pending_list_results.push_back(row.result);
          end
        end
        @(posedge clk_i);
      end while (!taken);
    end
    in_valid_i <= 1'b0;

    while (pending_list_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/ole_pkg.sv
src/ole_cell.sv
src/ole_chain.sv
src/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
